// File: rtl/dlr_pkg.sv
// ---------------------------------------------------------------------------
// DDA line and triangle rasteriser package
// Shared constants, request codes, edge codes and sequencer states.
// ---------------------------------------------------------------------------
package dlr_pkg;

   // Default geometry of the fixed-point datapath.
   localparam int COORD_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF  = 16;

   // Fixed field widths of the transaction payload.
   localparam int REQ_BITS   = 2;
   localparam int COLOR_BITS = 4;

   // Request codes carried on req_type.
   typedef enum logic [REQ_BITS-1:0] {
      REQ_LINE     = 2'd0,
      REQ_TRIANGLE = 2'd1,
      REQ_NEXT     = 2'd2
   } req_code_type;

   // Edge being drawn: A to B, B to C, C to A.
   typedef enum logic [1:0] {
      EDGE_AB = 2'd0,
      EDGE_BC = 2'd1,
      EDGE_CA = 2'd2
   } edge_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      S_READY,
      S_SETUP,
      S_DIV_X,
      S_DIV_Y,
      S_EMIT
   } state_type;

endpackage

// File: rtl/dlr_div.sv
// ---------------------------------------------------------------------------
// DDA rasteriser shared divider
// Restoring divider that produces one quotient bit per cycle. It computes
// (numer * 2^FRAC_BITS) / denom for numer <= denom, truncated.
// ---------------------------------------------------------------------------
module dlr_div #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] numer,
   input  logic [COORD_BITS-1:0] denom,
   output logic                  done,
   output logic [FRAC_BITS:0]    quot
);
   import dlr_pkg::*;

   localparam int QUOT_W = FRAC_BITS + 1;
   localparam int REM_W  = COORD_BITS + 1;
   localparam int CNT_W  = $clog2(FRAC_BITS + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [COORD_BITS-1:0] denom_ff, denom_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   logic [REM_W-1:0]  denom_ext;
   logic [REM_W-1:0]  diff;
   logic [REM_W-1:0]  rem_keep;
   logic              bit_ge;

   // One compare and subtract per cycle; the partial remainder then doubles.
   always_comb begin
      denom_ext = {1'b0, denom_ff};
      bit_ge    = (rem_ff >= denom_ext);
      diff      = rem_ff - denom_ext;
      rem_keep  = bit_ge ? diff : rem_ff;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quot_in  = quot_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(FRAC_BITS);
         rem_in   = {1'b0, numer};
         denom_in = denom;
      end else if (busy_ff) begin
         quot_in = {quot_ff[QUOT_W-2:0], bit_ge};
         rem_in  = {rem_keep[COORD_BITS-1:0], 1'b0};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quot_ff  <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: rtl/dda_line_triangle_rasterizer.sv
// ---------------------------------------------------------------------------
// DDA line and triangle rasteriser
// Draws a line or a triangle outline, one pixel per start or next request, using
// fixed-point accumulators and a shared iterative divider for the increments.
// ---------------------------------------------------------------------------
// A pixel inside an edge is returned in the cycle after its request, one per
// cycle while the result side does not stall. An edge setup (start, or a
// triangle moving to its next edge) runs a setup state, the x and y divisions
// in series and an emit state. A zero-length edge skips the divisions.
// The request side is stalled during setup and while a result waits to be taken.
// Reset is synchronous, active high, and leaves the block idle with no result.
module dda_line_triangle_rasterizer #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dlr_pkg::REQ_BITS-1:0]   req_type,
   input  logic [COORD_BITS-1:0]          req_start_x,
   input  logic [COORD_BITS-1:0]          req_start_y,
   input  logic [COORD_BITS-1:0]          req_end_x,
   input  logic [COORD_BITS-1:0]          req_end_y,
   input  logic [COORD_BITS-1:0]          req_third_x,
   input  logic [COORD_BITS-1:0]          req_third_y,
   input  logic [dlr_pkg::COLOR_BITS-1:0] req_pen_color,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [COORD_BITS-1:0]          rsp_pixel_x,
   output logic [COORD_BITS-1:0]          rsp_pixel_y,
   output logic [dlr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                           rsp_last_pixel
);
   import dlr_pkg::*;

   localparam int ACC_W  = COORD_BITS + 1 + FRAC_BITS;
   localparam int QUOT_W = FRAC_BITS + 1;
   localparam int STEP_W = FRAC_BITS + 2;
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int VTX_W  = 2 * COORD_BITS;
   localparam logic [ACC_W-1:0] HALF_ONE = ACC_W'(1) << (FRAC_BITS - 1);

   // Sequencer and figure state.
   state_type              state_ff, state_in;
   logic                   busy_ff, busy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   tri_ff, tri_in;
   edge_type               edge_ff, edge_in;
   logic [COLOR_BITS-1:0]  color_ff, color_in;
   logic [VTX_W-1:0]       vtx_a_ff, vtx_a_in;
   logic [VTX_W-1:0]       vtx_b_ff, vtx_b_in;
   logic [VTX_W-1:0]       vtx_c_ff, vtx_c_in;

   // Edge datapath.
   logic [ACC_W-1:0]       accum_x_ff, accum_x_in;
   logic [ACC_W-1:0]       accum_y_ff, accum_y_in;
   logic [STEP_W-1:0]      step_x_ff, step_x_in;
   logic [STEP_W-1:0]      step_y_ff, step_y_in;
   logic [COORD_BITS-1:0]  idx_ff, idx_in;
   logic [COORD_BITS-1:0]  total_ff, total_in;
   logic [COORD_BITS-1:0]  abs_dy_ff, abs_dy_in;
   logic                   neg_dx_ff, neg_dx_in;
   logic                   neg_dy_ff, neg_dy_in;

   // Combinational helpers.
   logic                   accept;
   logic                   last_edge;
   logic [COORD_BITS-1:0]  idx_next;
   logic [VTX_W-1:0]       from_v, to_v;
   logic [DIFF_W-1:0]      dx, dy, neg_dx, neg_dy;
   logic [COORD_BITS-1:0]  abs_dx, abs_dy, steps;
   logic [ACC_W-1:0]       round_x, round_y;
   logic [QUOT_W-1:0]      div_quot;
   logic [STEP_W-1:0]      signed_quot;
   logic                   div_start, div_done;
   logic [COORD_BITS-1:0]  div_numer, div_denom;

   // Shared divider for both increments of every edge.
   dlr_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Endpoints of the current edge and their differences.
   always_comb begin
      unique case (edge_ff)
         EDGE_AB: begin
            from_v = vtx_a_ff;
            to_v   = vtx_b_ff;
         end
         EDGE_BC: begin
            from_v = vtx_b_ff;
            to_v   = vtx_c_ff;
         end
         EDGE_CA: begin
            from_v = vtx_c_ff;
            to_v   = vtx_a_ff;
         end
         default: begin
            from_v = vtx_a_ff;
            to_v   = vtx_b_ff;
         end
      endcase
      dx     = {1'b0, to_v[VTX_W-1:COORD_BITS]} - {1'b0, from_v[VTX_W-1:COORD_BITS]};
      dy     = {1'b0, to_v[COORD_BITS-1:0]} - {1'b0, from_v[COORD_BITS-1:0]};
      neg_dx = -dx;
      neg_dy = -dy;
      abs_dx = dx[DIFF_W-1] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      abs_dy = dy[DIFF_W-1] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      steps  = (abs_dx > abs_dy) ? abs_dx : abs_dy;
   end

   // Divider operands: x during setup, y once the x quotient is back.
   always_comb begin
      if (state_ff == S_SETUP) begin
         div_numer = abs_dx;
         div_denom = steps;
      end else begin
         div_numer = abs_dy_ff;
         div_denom = total_ff;
      end
   end

   assign accept    = (state_ff == S_READY) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !accept;
   assign last_edge = !tri_ff || (edge_ff == EDGE_CA);
   assign idx_next  = idx_ff + 1'b1;

   // Sequencer: next state, figure state and datapath loads.
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tri_in       = tri_ff;
      edge_in      = edge_ff;
      color_in     = color_ff;
      vtx_a_in     = vtx_a_ff;
      vtx_b_in     = vtx_b_ff;
      vtx_c_in     = vtx_c_ff;
      accum_x_in   = accum_x_ff;
      accum_y_in   = accum_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      abs_dy_in    = abs_dy_ff;
      neg_dx_in    = neg_dx_ff;
      neg_dy_in    = neg_dy_ff;
      div_start    = 1'b0;
      signed_quot  = {1'b0, div_quot};

      unique case (state_ff)
         S_READY: begin
            if (req_valid && accept) begin
               unique case (req_code_type'(req_type))
                  REQ_LINE, REQ_TRIANGLE: begin
                     vtx_a_in = {req_start_x, req_start_y};
                     vtx_b_in = {req_end_x, req_end_y};
                     vtx_c_in = {req_third_x, req_third_y};
                     color_in = req_pen_color;
                     tri_in   = (req_code_type'(req_type) == REQ_TRIANGLE);
                     edge_in  = EDGE_AB;
                     busy_in  = 1'b1;
                     state_in = S_SETUP;
                  end
                  REQ_NEXT: begin
                     if (busy_ff) begin
                        if (idx_ff < total_ff) begin
                           // Inside the edge: one increment, result at once.
                           accum_x_in = accum_x_ff +
                              {{(ACC_W-STEP_W){step_x_ff[STEP_W-1]}}, step_x_ff};
                           accum_y_in = accum_y_ff +
                              {{(ACC_W-STEP_W){step_y_ff[STEP_W-1]}}, step_y_ff};
                           idx_in       = idx_next;
                           rsp_valid_in = 1'b1;
                           busy_in      = !((idx_next == total_ff) && last_edge);
                        end else begin
                           // Edge finished: move the triangle to its next edge.
                           unique case (edge_ff)
                              EDGE_AB: edge_in = EDGE_BC;
                              default: edge_in = EDGE_CA;
                           endcase
                           state_in = S_SETUP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SETUP: begin
            // Load the accumulators and start the x division unless the edge has zero length.
            accum_x_in = {1'b0, from_v[VTX_W-1:COORD_BITS], {FRAC_BITS{1'b0}}};
            accum_y_in = {1'b0, from_v[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
            idx_in     = '0;
            total_in   = steps;
            abs_dy_in  = abs_dy;
            neg_dx_in  = dx[DIFF_W-1];
            neg_dy_in  = dy[DIFF_W-1];
            if (steps == '0) begin
               // Zero-length edge: no division, a single pixel.
               step_x_in = '0;
               step_y_in = '0;
               state_in  = S_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_X;
            end
         end
         S_DIV_X: begin
            if (div_done) begin
               step_x_in = neg_dx_ff ? -signed_quot : signed_quot;
               div_start = 1'b1;
               state_in  = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (div_done) begin
               step_y_in = neg_dy_ff ? -signed_quot : signed_quot;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            // First pixel of the edge.
            rsp_valid_in = 1'b1;
            busy_in      = !((total_ff == '0) && last_edge);
            state_in     = S_READY;
         end
         default: begin
            state_in = S_READY;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READY;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Figure and edge registers.
   always_ff @(posedge clock) begin
      tri_ff     <= tri_in;
      edge_ff    <= edge_in;
      color_ff   <= color_in;
      vtx_a_ff   <= vtx_a_in;
      vtx_b_ff   <= vtx_b_in;
      vtx_c_ff   <= vtx_c_in;
      accum_x_ff <= accum_x_in;
      accum_y_ff <= accum_y_in;
      step_x_ff  <= step_x_in;
      step_y_ff  <= step_y_in;
      idx_ff     <= idx_in;
      total_ff   <= total_in;
      abs_dy_ff  <= abs_dy_in;
      neg_dx_ff  <= neg_dx_in;
      neg_dy_ff  <= neg_dy_in;
   end

   // Result: rounded accumulators, held steady while a transaction waits.
   assign round_x         = accum_x_ff + HALF_ONE;
   assign round_y         = accum_y_ff + HALF_ONE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = round_x[FRAC_BITS +: COORD_BITS];
   assign rsp_pixel_y     = round_y[FRAC_BITS +: COORD_BITS];
   assign rsp_pixel_color = color_ff;
   assign rsp_last_pixel  = (idx_ff == total_ff) && last_edge;

endmodule

// File: rtl/dlr_checker.sv
// ---------------------------------------------------------------------------
// DDA rasteriser port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ---------------------------------------------------------------------------
module dlr_checker #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [dlr_pkg::REQ_BITS-1:0]   req_type,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [COORD_BITS-1:0]          rsp_pixel_x,
   input logic [COORD_BITS-1:0]          rsp_pixel_y,
   input logic [dlr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   input logic                           rsp_last_pixel
);
   import dlr_pkg::*;

   logic start_acc;

   assign start_acc = req_valid && !req_stall &&
                      (req_type == REQ_LINE || req_type == REQ_TRIANGLE);

   // A stalled result transaction keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x) &&
         $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last_pixel))
      else $error("stalled result changed");

   // No request is taken while a result is held back.
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while result stalled");

   // A start needs edge setup, so no result follows in the next cycle.
   a_start_no_result: assert property (@(posedge clock) disable iff (reset)
      start_acc |=> !rsp_valid)
      else $error("result straight after start");

   // The block is busy with setup right after a start.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_acc |=> req_stall)
      else $error("request side ready during edge setup");

endmodule

bind dda_line_triangle_rasterizer dlr_checker #(
   .COORD_BITS (COORD_BITS)
) u_dlr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_last_pixel  (rsp_last_pixel)
);

// File: tb/sv/dlr_pixel_checker.sv
// ---------------------------------------------------------------------------
// DDA rasteriser pixel checker
// Watches the request and pixel channels of the rasteriser, predicts every
// pixel from the accepted requests and compares each accepted pixel with the
// oldest prediction still outstanding.
// ---------------------------------------------------------------------------
module dlr_pixel_checker #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [dlr_pkg::REQ_BITS-1:0]   req_type,
   input  logic [COORD_BITS-1:0]          req_start_x,
   input  logic [COORD_BITS-1:0]          req_start_y,
   input  logic [COORD_BITS-1:0]          req_end_x,
   input  logic [COORD_BITS-1:0]          req_end_y,
   input  logic [COORD_BITS-1:0]          req_third_x,
   input  logic [COORD_BITS-1:0]          req_third_y,
   input  logic [dlr_pkg::COLOR_BITS-1:0] req_pen_color,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [COORD_BITS-1:0]          rsp_pixel_x,
   input  logic [COORD_BITS-1:0]          rsp_pixel_y,
   input  logic [dlr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   input  logic                           rsp_last_pixel,
   output int                             fail_count,
   output int                             pending,
   output int                             pixels_checked
);
   import dlr_pkg::*;

   localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 1;

   typedef logic signed [ACC_BITS-1:0] fixed_type;
   typedef logic [COORD_BITS-1:0] coord_type;
   typedef struct packed {
      coord_type             x;
      coord_type             y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   // Predicted rasteriser state.
   fixed_type             acc_x, acc_y, inc_x, inc_y;
   logic [COORD_BITS:0]   pix_index, pix_total;
   logic [COLOR_BITS-1:0] pen;
   logic                  drawing, is_triangle;
   edge_type              cur_edge;
   coord_type             vert_x [3];
   coord_type             vert_y [3];

   pixel_type expected_pixels [$];
   int        mismatches = 0;
   int        compared   = 0;

   // Set up the accumulators and increments for the edge from one stored vertex to another.
   function automatic void load_edge(input logic [1:0] src, input logic [1:0] dst);
      longint dx, dy, adx, ady, span;
      dx   = longint'(vert_x[dst]) - longint'(vert_x[src]);
      dy   = longint'(vert_y[dst]) - longint'(vert_y[src]);
      adx  = (dx < 0) ? -dx : dx;
      ady  = (dy < 0) ? -dy : dy;
      span = (adx > ady) ? adx : ady;
      // A zero-length edge has no increments and gives a single pixel.
      if (span == 0) begin
         inc_x = '0;
         inc_y = '0;
      end else begin
         inc_x = fixed_type'((dx * (longint'(1) << FRAC_BITS)) / span);
         inc_y = fixed_type'((dy * (longint'(1) << FRAC_BITS)) / span);
      end
      acc_x     = fixed_type'(longint'(vert_x[src]) << FRAC_BITS);
      acc_y     = fixed_type'(longint'(vert_y[src]) << FRAC_BITS);
      pix_total = span[COORD_BITS:0];
      pix_index = '0;
   endfunction

   // Round the accumulators half up and flag the final pixel of the figure.
   function automatic pixel_type plot_pixel();
      fixed_type half, sum_x, sum_y;
      pixel_type p;
      half    = fixed_type'(longint'(1) << (FRAC_BITS - 1));
      sum_x   = acc_x + half;
      sum_y   = acc_y + half;
      p.x     = sum_x[FRAC_BITS +: COORD_BITS];
      p.y     = sum_y[FRAC_BITS +: COORD_BITS];
      p.color = pen;
      p.last  = (pix_index == pix_total) && (!is_triangle || cur_edge == EDGE_CA);
      if (p.last)
         drawing = 1'b0;
      return p;
   endfunction

   // Advance the prediction by one accepted request transaction.
   function automatic void raster_request();
      case (req_type)
         REQ_LINE, REQ_TRIANGLE: begin
            vert_x[0]   = req_start_x;
            vert_y[0]   = req_start_y;
            vert_x[1]   = req_end_x;
            vert_y[1]   = req_end_y;
            vert_x[2]   = req_third_x;
            vert_y[2]   = req_third_y;
            pen         = req_pen_color;
            is_triangle = (req_type == REQ_TRIANGLE);
            cur_edge    = EDGE_AB;
            drawing     = 1'b1;
            load_edge(2'd0, 2'd1);
            expected_pixels.push_back(plot_pixel());
         end
         REQ_NEXT: begin
            // A next request while idle gives nothing.
            if (drawing) begin
               if (pix_index < pix_total) begin
                  acc_x     = acc_x + inc_x;
                  acc_y     = acc_y + inc_y;
                  pix_index = pix_index + 1'b1;
               end else if (cur_edge == EDGE_AB) begin
                  cur_edge = EDGE_BC;
                  load_edge(2'd1, 2'd2);
               end else begin
                  cur_edge = EDGE_CA;
                  load_edge(2'd2, 2'd0);
               end
               expected_pixels.push_back(plot_pixel());
            end
         end
         default: ;
      endcase
   endfunction

   // Compare one accepted pixel transaction with the oldest prediction.
   function automatic void check_pixel();
      pixel_type got, want;
      got.x     = rsp_pixel_x;
      got.y     = rsp_pixel_y;
      got.color = rsp_pixel_color;
      got.last  = rsp_last_pixel;
      if (expected_pixels.size() == 0) begin
         if (mismatches < 10)
            $display("unexpected pixel x=%0d y=%0d colour=%0d last=%0b with none outstanding",
                     got.x, got.y, got.color, got.last);
         mismatches++;
      end else begin
         want = expected_pixels.pop_front();
         compared++;
         if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
             got.last !== want.last) begin
            if (mismatches < 10)
               $display({"pixel %0d: expected x=%0d y=%0d colour=%0d last=%0b, ",
                         "got x=%0d y=%0d colour=%0d last=%0b"},
                        compared, want.x, want.y, want.color, want.last,
                        got.x, got.y, got.color, got.last);
            mismatches++;
         end
      end
   endfunction

   // Pixels are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         acc_x       = '0;
         acc_y       = '0;
         inc_x       = '0;
         inc_y       = '0;
         pix_index   = '0;
         pix_total   = '0;
         pen         = '0;
         drawing     = 1'b0;
         is_triangle = 1'b0;
         cur_edge    = EDGE_AB;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_pixel();
         if (req_valid && !req_stall)
            raster_request();
      end
      fail_count     <= mismatches;
      pending        <= expected_pixels.size();
      pixels_checked <= compared;
   end

endmodule

// File: tb/sv/tb_dda_line_triangle_rasterizer.sv
// ---------------------------------------------------------------------------
// DDA rasteriser testbench
// Drives directed and random line and triangle figures into the rasteriser
// with random gaps and pixel back-pressure; a checker beside the block
// predicts and compares every pixel, and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_dda_line_triangle_rasterizer;
   import dlr_pkg::*;

   localparam int COORD_BITS   = COORD_BITS_DEF;
   localparam int FRAC_BITS    = FRAC_BITS_DEF;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int SETUP_CYCLES = 2 * FRAC_BITS + 7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEM_TARGET  = 500;

   // Request code that the block ignores.
   localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

   typedef logic [COORD_BITS-1:0] coord_type;

   // Far corner of the screen.
   localparam coord_type COORD_TOP = coord_type'(COORD_MAX);

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [REQ_BITS-1:0]   req_type        = REQ_NEXT;
   coord_type             req_start_x     = '0;
   coord_type             req_start_y     = '0;
   coord_type             req_end_x       = '0;
   coord_type             req_end_y       = '0;
   coord_type             req_third_x     = '0;
   coord_type             req_third_y     = '0;
   logic [COLOR_BITS-1:0] req_pen_color   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   coord_type             rsp_pixel_x;
   coord_type             rsp_pixel_y;
   logic [COLOR_BITS-1:0] rsp_pixel_color;
   logic                  rsp_last_pixel;

   int fail_count;
   int pending;
   int pixels_checked;

   bit quiet_sender   = 1'b0;
   bit quiet_receiver = 1'b0;
   int cycle_count    = 0;
   int figure_items   = 0;
   int line_starts    = 0;
   int tri_starts     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dda_line_triangle_rasterizer #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_third_x    (req_third_x),
      .req_third_y    (req_third_y),
      .req_pen_color  (req_pen_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel)
   );

   dlr_pixel_checker #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_third_x    (req_third_x),
      .req_third_y    (req_third_y),
      .req_pen_color  (req_pen_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel),
      .fail_count     (fail_count),
      .pending        (pending),
      .pixels_checked (pixels_checked)
   );

   // Pixel back-pressure: random stalls except during the quiet stretch.
   always @(posedge clock) begin
      if (quiet_receiver)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 35);
   end

   // Present one request transaction after a random gap and hold it until accepted.
   task automatic send_request(input logic [REQ_BITS-1:0] kind,
                               input coord_type ax, input coord_type ay,
                               input coord_type bx, input coord_type by,
                               input coord_type cx, input coord_type cy,
                               input logic [COLOR_BITS-1:0] color);
      if (!quiet_sender) begin
         while ($urandom_range(99) < 35) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_start_x   <= ax;
      req_start_y   <= ay;
      req_end_x     <= bx;
      req_end_y     <= by;
      req_third_x   <= cx;
      req_third_y   <= cy;
      req_pen_color <= color;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // A request whose payload the block does not read.
   task automatic send_filler(input logic [REQ_BITS-1:0] kind);
      send_request(kind, coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom),
                   COLOR_BITS'($urandom));
   endtask

   // Stop sending and wait until every predicted pixel has been seen.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETUP_CYCLES + 10) @(posedge clock);
   endtask

   function automatic coord_type pick_base();
      case ($urandom_range(9))
         0:       return '0;
         1:       return COORD_TOP;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // A coordinate within a few pixels of the base, clamped to the screen.
   function automatic coord_type near_coord(input coord_type base);
      int v;
      v = int'(base) + int'($urandom_range(12)) - 6;
      if (v < 0)
         v = 0;
      if (v > COORD_MAX)
         v = COORD_MAX;
      return coord_type'(v);
   endfunction

   function automatic int edge_span(input coord_type x0, input coord_type y0,
                                    input coord_type x1, input coord_type y1);
      int dx, dy;
      dx = int'(x1) - int'(x0);
      dy = int'(y1) - int'(y0);
      if (dx < 0)
         dx = -dx;
      if (dy < 0)
         dy = -dy;
      return (dx > dy) ? dx : dy;
   endfunction

   // One random figure: mostly short edges drawn to the end, some cut short
   // by the next start, some followed by stray requests, a few long ones.
   task automatic random_figure();
      coord_type           ax, ay, bx, by, cx, cy;
      logic [REQ_BITS-1:0] kind;
      int                  pixels, nexts, n;
      bit                  long_fig;
      kind     = ($urandom_range(1) == 0) ? REQ_LINE : REQ_TRIANGLE;
      long_fig = ($urandom_range(24) == 0);
      ax       = pick_base();
      ay       = pick_base();
      if (long_fig) begin
         bx = coord_type'($urandom);
         by = coord_type'($urandom);
         cx = coord_type'($urandom);
         cy = coord_type'($urandom);
      end else begin
         bx = near_coord(ax);
         by = near_coord(ay);
         cx = near_coord(bx);
         cy = near_coord(by);
         // Zero-length edges now and then.
         if ($urandom_range(9) == 0) begin
            bx = ax;
            by = ay;
         end
         if ($urandom_range(9) == 0) begin
            cx = bx;
            cy = by;
         end
      end
      pixels = edge_span(ax, ay, bx, by) + 1;
      if (kind == REQ_TRIANGLE)
         pixels += edge_span(bx, by, cx, cy) + edge_span(cx, cy, ax, ay) + 2;
      case ($urandom_range(9))
         0:       nexts = $urandom_range(pixels - 1);
         1:       nexts = pixels - 1 + $urandom_range(3, 1);
         default: nexts = pixels - 1;
      endcase
      if (long_fig)
         nexts = $urandom_range(40, 5);
      send_request(kind, ax, ay, bx, by, cx, cy, COLOR_BITS'($urandom));
      if (kind == REQ_LINE)
         line_starts++;
      else
         tri_starts++;
      figure_items++;
      for (n = 0; n < nexts; n++) begin
         if ($urandom_range(29) == 0)
            send_filler(REQ_UNUSED);
         send_filler(REQ_NEXT);
         if (n < pixels - 1)
            figure_items++;
      end
   endtask

   // Run limit.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("dda_line_triangle_rasterizer: mismatch");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int figures;
      figures = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Next while idle, and the unused request code.
      send_filler(REQ_NEXT);
      send_filler(REQ_UNUSED);
      // Full-screen diagonal, dropped by a new start while busy.
      send_request(REQ_LINE, 0, 0, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 4'hF);
      send_filler(REQ_NEXT);
      send_request(REQ_LINE, COORD_TOP, 0, 0, COORD_TOP, 0, 0, 4'h0);
      send_filler(REQ_NEXT);
      // Half-pixel steps in x exercise the round-half-up.
      send_request(REQ_LINE, 0, 0, 1, 2, 0, 0, 4'h9);
      send_filler(REQ_NEXT);
      send_filler(REQ_NEXT);
      send_filler(REQ_NEXT);
      // Zero-length line: one pixel, flagged last.
      send_request(REQ_LINE, 7, 7, 7, 7, COORD_TOP, 0, 4'h5);
      // Small triangle with shared vertices repeated.
      send_request(REQ_TRIANGLE, 0, 0, 1, 1, 0, 1, 4'hA);
      repeat (5) send_filler(REQ_NEXT);
      // Triangle collapsed to one point at the far corner.
      send_request(REQ_TRIANGLE, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP,
                   COORD_TOP, COORD_TOP, 4'h3);
      repeat (2) send_filler(REQ_NEXT);
      // Triangle with one zero-length edge and an ignored request in the middle.
      send_request(REQ_TRIANGLE, 2, 0, 0, 0, 0, 0, 4'h6);
      send_filler(REQ_UNUSED);
      repeat (6) send_filler(REQ_NEXT);
      wait_drained();

      // Random figures, with a quiet stretch and a full drain now and then.
      while (figure_items < ITEM_TARGET) begin
         quiet_sender   = (figure_items >= 200 && figure_items < 300);
         quiet_receiver = quiet_sender;
         random_figure();
         figures++;
         if (figures % 60 == 0)
            wait_drained();
      end
      quiet_sender   = 1'b0;
      quiet_receiver = 1'b0;
      wait_drained();

      $display("Drew %0d lines and %0d triangles over about %0d pixel requests;",
               line_starts, tri_starts, figure_items);
      $display("%0d pixels compared, with zero-length edges, interrupted figures, %s",
               pixels_checked, "idle and unused requests.");
      if (fail_count == 0 && pending == 0)
         $display("dda_line_triangle_rasterizer: match");
      else
         $display("dda_line_triangle_rasterizer: mismatch");
      $finish;
   end

endmodule

// File: files.f
rtl/dlr_pkg.sv
rtl/dlr_div.sv
rtl/dda_line_triangle_rasterizer.sv
rtl/dlr_checker.sv
tb/sv/dlr_pixel_checker.sv
tb/sv/tb_dda_line_triangle_rasterizer.sv
